// ----- src/knn_pkg.sv -----
// Shared types and constants of the k-nearest-neighbor classifier.
// No dependencies; every other file of the block but knn_ram uses this package.
`default_nettype none

package knn_pkg;

  // Fixed field widths
  localparam int unsigned FEATURE_COUNT = 4;
  localparam int unsigned FEAT_W        = 24;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_W         = 24;
  localparam int unsigned SQ_W          = 2 * FEAT_W + 2;
  localparam int unsigned DIST_W        = SQ_W + 2;

  // Parameter defaults
  localparam int unsigned DEF_MAX_POINTS     = 64;
  localparam int unsigned DEF_NEIGHBOR_COUNT = 3;

  // Function codes of an input transaction
  localparam logic FUNC_LOAD     = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  // Register map: means first, then reciprocal scales
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BASE  = 3'd4;
  localparam logic [CFG_W-1:0]     INV_RESET     = 24'd65536;

  typedef logic signed [FEAT_W-1:0] feat_t;

endpackage

`default_nettype wire

// ----- src/knn_if.sv -----
// Valid/ready channel interfaces for query/load items and for results.
// Depends on knn_pkg for field widths.
`default_nettype none

interface knn_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [knn_pkg::IDX_W-1:0]  point_index;
  knn_pkg::feat_t             feature_0;
  knn_pkg::feat_t             feature_1;
  knn_pkg::feat_t             feature_2;
  knn_pkg::feat_t             feature_3;
  logic                       point_label;

  modport source (
    output valid, func, point_index, feature_0, feature_1, feature_2, feature_3,
           point_label,
    input  ready
  );
  modport sink (
    input  valid, func, point_index, feature_0, feature_1, feature_2, feature_3,
           point_label,
    output ready
  );
endinterface

interface knn_out_if;
  logic                       valid;
  logic                       ready;
  logic                       prediction;
  logic [1:0]                 neighbors_found;
  logic [knn_pkg::IDX_W-1:0]  nearest_index;

  modport source (
    output valid, prediction, neighbors_found, nearest_index,
    input  ready
  );
  modport sink (
    input  valid, prediction, neighbors_found, nearest_index,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/knn_binary_classifier.sv -----
// Top level of the k-nearest-neighbor binary classifier.
// Depends on knn_pkg, knn_if, knn_ram and knn_cell.
//
// Usage:
//   in_i carries load and classify transactions (valid/ready). A load writes
//   one standardized training point into slot point_index; it leaves the
//   block idle and produces no result. A classify standardizes the four raw
//   features through one shared multiplier, streams all MAX_POINTS slots
//   from the point RAM at one slot per cycle, squares and sums the
//   differences, and pushes each valid distance into a chain of
//   NEIGHBOR_COUNT sorting cells. After the chain drains the vote is
//   registered on out_o. The time a classify occupies the block is set
//   mainly by the one-slot-per-cycle RAM scan.
//   The result sits in an output register; the block accepts new items
//   while it waits, and a finished classify holds until that register
//   frees. Configuration (cfg_we_i/cfg_idx_i/cfg_data_i) must be written
//   only while the block is idle; the block itself does not enforce this.
//   After reset a clearing pass over all MAX_POINTS slots marks every slot
//   invalid; in_i.ready stays low until it ends.
`default_nettype none

module knn_binary_classifier #(
  parameter int unsigned MAX_POINTS     = knn_pkg::DEF_MAX_POINTS,
  parameter int unsigned NEIGHBOR_COUNT = knn_pkg::DEF_NEIGHBOR_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  knn_in_if.sink                        in_i,
  knn_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [knn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [knn_pkg::CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned NF     = knn_pkg::FEATURE_COUNT;
  localparam int unsigned FW     = $clog2(NF);
  localparam int unsigned FEAT_W = knn_pkg::FEAT_W;
  localparam int unsigned AW     = $clog2(MAX_POINTS);
  localparam int unsigned CW     = $clog2(NEIGHBOR_COUNT + 1);
  localparam int unsigned ROW_W  = NF * FEAT_W + 1;
  localparam int unsigned PROD_W = 2 * FEAT_W + 2;
  localparam int unsigned SH_W   = PROD_W - 16;
  localparam int unsigned SQ_W   = knn_pkg::SQ_W;
  localparam int unsigned DIST_W = knn_pkg::DIST_W;

  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);
  localparam logic signed [SH_W-1:0]   SAT_HI   = SH_W'(2 ** (FEAT_W - 1) - 1);
  localparam logic signed [SH_W-1:0]   SAT_LO   = ~SAT_HI;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STD,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Round to nearest (ties up) from Q.16 and saturate to the feature range
  function automatic knn_pkg::feat_t round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    logic signed [SH_W-1:0]   s;
    r = p + HALF_LSB;
    s = r[PROD_W-1:16];
    if (s > SAT_HI) begin
      round_sat = SAT_HI[FEAT_W-1:0];
    end else if (s < SAT_LO) begin
      round_sat = SAT_LO[FEAT_W-1:0];
    end else begin
      round_sat = s[FEAT_W-1:0];
    end
  endfunction

  state_e                 state_q;
  logic [AW-1:0]          cnt_q;
  logic [FW:0]            std_cnt_q;
  logic                   d_vld_q;
  logic [FW-1:0]          d_f_q;
  logic                   p_vld_q;
  logic [FW-1:0]          p_f_q;
  logic                   rd_vld_q;
  logic [AW-1:0]          rd_idx_q;
  logic                   sq_vld_q;
  logic [AW-1:0]          sq_idx_q;
  logic                   sq_lbl_q;
  logic                   sum_vld_q;
  logic [AW-1:0]          sum_idx_q;
  logic                   sum_lbl_q;
  logic [DIST_W-1:0]      sum_q;
  logic                   out_vld_q;
  logic                   out_pred_q;
  logic [1:0]             out_found_q;
  logic [knn_pkg::IDX_W-1:0] out_near_q;

  knn_pkg::feat_t         mean_q [NF];
  logic [knn_pkg::CFG_W-1:0] inv_q [NF];
  knn_pkg::feat_t         raw_q  [NF];
  knn_pkg::feat_t         std_q  [NF];
  logic signed [FEAT_W:0] diff_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SQ_W-1:0]        sq_q   [NF];

  logic                   in_acc;
  logic                   load_we;
  logic                   query_go;
  logic [AW-1:0]          load_addr;
  logic [ROW_W-1:0]       row_wdata;
  logic [ROW_W-1:0]       row_rdata;
  logic                   vld_we;
  logic [AW-1:0]          vld_waddr;
  logic                   vld_wdata;
  logic                   vld_rdata;
  logic signed [FEAT_W:0] diff_d;
  logic signed [PROD_W-1:0] prod_d;
  logic [SQ_W-1:0]        sq_d   [NF];
  logic [DIST_W-1:0]      sum_d;
  logic                   busy;
  logic [CW-1:0]          found;
  logic [CW-1:0]          ones;
  logic                   pred;

  // Cell chain wiring
  logic                   c_vld  [NEIGHBOR_COUNT];
  logic [DIST_W-1:0]      c_dist [NEIGHBOR_COUNT];
  logic [AW-1:0]          c_idx  [NEIGHBOR_COUNT];
  logic                   c_lbl  [NEIGHBOR_COUNT];
  logic                   k_occ  [NEIGHBOR_COUNT];
  logic [AW-1:0]          k_idx  [NEIGHBOR_COUNT];
  logic                   k_lbl  [NEIGHBOR_COUNT];
  logic                   last_vld;

  // Input handshake and load decode
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load_addr  = AW'(in_i.point_index);
  assign load_we    = in_acc && (in_i.func == knn_pkg::FUNC_LOAD) &&
                      (32'(in_i.point_index) < MAX_POINTS);
  assign query_go   = in_acc && (in_i.func == knn_pkg::FUNC_CLASSIFY);
  assign row_wdata  = {in_i.point_label, in_i.feature_3, in_i.feature_2,
                       in_i.feature_1, in_i.feature_0};

  // Valid store: cleared by the sweep after reset, set by loads
  assign vld_we    = (state_q == ST_CLEAR) || load_we;
  assign vld_waddr = (state_q == ST_CLEAR) ? cnt_q : load_addr;
  assign vld_wdata = (state_q != ST_CLEAR);

  knn_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_addr),
    .wdata_i (row_wdata),
    .raddr_i (cnt_q),
    .rdata_o (row_rdata)
  );

  knn_ram #(.WIDTH(1), .DEPTH(MAX_POINTS)) u_vld_ram (
    .clk_i   (clk_i),
    .we_i    (vld_we),
    .waddr_i (vld_waddr),
    .wdata_i (vld_wdata),
    .raddr_i (cnt_q),
    .rdata_o (vld_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NF; i++) begin
        mean_q[i] <= '0;
        inv_q[i]  <= knn_pkg::INV_RESET;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < knn_pkg::CFG_INV_BASE) begin
        mean_q[cfg_idx_i[FW-1:0]] <= cfg_data_i;
      end else begin
        inv_q[cfg_idx_i[FW-1:0]] <= cfg_data_i;
      end
    end
  end

  // Standardize datapath: subtract, then multiply by reciprocal scale
  assign diff_d = (FEAT_W + 1)'(raw_q[std_cnt_q[FW-1:0]]) -
                  (FEAT_W + 1)'(mean_q[std_cnt_q[FW-1:0]]);
  assign prod_d = diff_q * $signed({1'b0, inv_q[d_f_q]});

  // Squared differences to the stored row
  always_comb begin
    logic signed [FEAT_W:0] sd;
    logic signed [SQ_W-1:0] sp;
    for (int f = 0; f < NF; f++) begin
      sd = (FEAT_W + 1)'(std_q[f]) -
           (FEAT_W + 1)'($signed(row_rdata[f*FEAT_W +: FEAT_W]));
      sp = sd * sd;
      sq_d[f] = sp;
    end
  end

  always_comb begin
    sum_d = '0;
    for (int f = 0; f < NF; f++) begin
      sum_d = sum_d + DIST_W'(sq_q[f]);
    end
  end

  // Payload pipeline registers
  always_ff @(posedge clk_i) begin
    if (query_go) begin
      raw_q[0] <= in_i.feature_0;
      raw_q[1] <= in_i.feature_1;
      raw_q[2] <= in_i.feature_2;
      raw_q[3] <= in_i.feature_3;
    end
    diff_q <= diff_d;
    prod_q <= prod_d;
    if (p_vld_q) begin
      std_q[p_f_q] <= round_sat(prod_q);
    end
    rd_idx_q  <= cnt_q;
    sq_idx_q  <= rd_idx_q;
    sq_lbl_q  <= row_rdata[ROW_W-1];
    sq_q      <= sq_d;
    sum_idx_q <= sq_idx_q;
    sum_lbl_q <= sq_lbl_q;
    sum_q     <= sum_d;
  end

  // Sorting chain
  assign c_vld[0]  = sum_vld_q;
  assign c_dist[0] = sum_q;
  assign c_idx[0]  = sum_idx_q;
  assign c_lbl[0]  = sum_lbl_q;

  for (genvar j = 0; j < NEIGHBOR_COUNT; j++) begin : g_cell
    if (j == NEIGHBOR_COUNT - 1) begin : g_last
      knn_cell #(.IW(AW)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .clear_i    (query_go),
        .in_vld_i   (c_vld[j]),
        .in_dist_i  (c_dist[j]),
        .in_idx_i   (c_idx[j]),
        .in_lbl_i   (c_lbl[j]),
        .out_vld_o  (last_vld),
        .out_dist_o (),
        .out_idx_o  (),
        .out_lbl_o  (),
        .occ_o      (k_occ[j]),
        .idx_o      (k_idx[j]),
        .lbl_o      (k_lbl[j])
      );
    end else begin : g_mid
      knn_cell #(.IW(AW)) u_cell (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .clear_i    (query_go),
        .in_vld_i   (c_vld[j]),
        .in_dist_i  (c_dist[j]),
        .in_idx_i   (c_idx[j]),
        .in_lbl_i   (c_lbl[j]),
        .out_vld_o  (c_vld[j+1]),
        .out_dist_o (c_dist[j+1]),
        .out_idx_o  (c_idx[j+1]),
        .out_lbl_o  (c_lbl[j+1]),
        .occ_o      (k_occ[j]),
        .idx_o      (k_idx[j]),
        .lbl_o      (k_lbl[j])
      );
    end
  end

  // Anything still moving through the scan pipeline or the chain
  always_comb begin
    busy = rd_vld_q || sq_vld_q || last_vld;
    for (int j = 0; j < NEIGHBOR_COUNT; j++) begin
      busy = busy || c_vld[j];
    end
  end

  // Majority vote over occupied cells
  always_comb begin
    found = '0;
    ones  = '0;
    for (int j = 0; j < NEIGHBOR_COUNT; j++) begin
      found = found + CW'(k_occ[j]);
      ones  = ones + CW'(k_occ[j] && k_lbl[j]);
    end
    pred = ({ones, 1'b0} > {1'b0, found});
  end

  // Sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      std_cnt_q   <= '0;
      d_vld_q     <= 1'b0;
      d_f_q       <= '0;
      p_vld_q     <= 1'b0;
      p_f_q       <= '0;
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      sum_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      out_pred_q  <= 1'b0;
      out_found_q <= '0;
      out_near_q  <= '0;
    end else begin
      rd_vld_q  <= (state_q == ST_SCAN);
      sq_vld_q  <= rd_vld_q && vld_rdata;
      sum_vld_q <= sq_vld_q;
      p_vld_q   <= d_vld_q;
      p_f_q     <= d_f_q;
      d_vld_q   <= 1'b0;
      if (out_vld_q && out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(MAX_POINTS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (query_go) begin
            std_cnt_q <= '0;
            state_q   <= ST_STD;
          end
        end
        ST_STD: begin
          if (std_cnt_q < (FW + 1)'(NF)) begin
            d_vld_q   <= 1'b1;
            d_f_q     <= std_cnt_q[FW-1:0];
            std_cnt_q <= std_cnt_q + 1'b1;
          end
          if (p_vld_q && (p_f_q == FW'(NF - 1))) begin
            cnt_q   <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == AW'(MAX_POINTS - 1)) begin
            cnt_q   <= '0;
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q   <= 1'b1;
            out_pred_q  <= pred;
            out_found_q <= 2'(found);
            out_near_q  <= k_occ[0] ? knn_pkg::IDX_W'(k_idx[0]) : '0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.prediction      = out_pred_q;
  assign out_o.neighbors_found = out_found_q;
  assign out_o.nearest_index   = out_near_q;

endmodule

`default_nettype wire

// ----- src/knn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module knn_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/knn_cell.sv -----
// One slot of the sorted neighbor chain: keeps the best candidate seen and
// hands the loser on to the next cell through a register. Depends on knn_pkg.
`default_nettype none

module knn_cell #(
  parameter int unsigned IW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       in_vld_i,
  input  logic [knn_pkg::DIST_W-1:0] in_dist_i,
  input  logic [IW-1:0]              in_idx_i,
  input  logic                       in_lbl_i,
  output logic                       out_vld_o,
  output logic [knn_pkg::DIST_W-1:0] out_dist_o,
  output logic [IW-1:0]              out_idx_o,
  output logic                       out_lbl_o,
  output logic                       occ_o,
  output logic [IW-1:0]              idx_o,
  output logic                       lbl_o
);

  logic                       occ_q;
  logic [knn_pkg::DIST_W-1:0] dist_q;
  logic [IW-1:0]              idx_q;
  logic                       lbl_q;
  logic                       pass_vld_q;
  logic [knn_pkg::DIST_W-1:0] pass_dist_q;
  logic [IW-1:0]              pass_idx_q;
  logic                       pass_lbl_q;
  logic                       take;

  // Ordered by distance, then by slot: the lower slot wins a tie even when
  // the chain delivers it after a higher one
  assign take = in_vld_i && (!occ_q || (in_dist_i < dist_q) ||
                             ((in_dist_i == dist_q) && (in_idx_i < idx_q)));

  // Control: occupancy and pass-on valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= 1'b0;
      pass_vld_q <= 1'b0;
    end else if (clear_i) begin
      occ_q      <= 1'b0;
      pass_vld_q <= 1'b0;
    end else begin
      pass_vld_q <= in_vld_i && (!take || occ_q);
      if (take) begin
        occ_q <= 1'b1;
      end
    end
  end

  // Payload: kept entry and entry handed on
  always_ff @(posedge clk_i) begin
    if (take) begin
      dist_q      <= in_dist_i;
      idx_q       <= in_idx_i;
      lbl_q       <= in_lbl_i;
      pass_dist_q <= dist_q;
      pass_idx_q  <= idx_q;
      pass_lbl_q  <= lbl_q;
    end else begin
      pass_dist_q <= in_dist_i;
      pass_idx_q  <= in_idx_i;
      pass_lbl_q  <= in_lbl_i;
    end
  end

  assign out_vld_o  = pass_vld_q;
  assign out_dist_o = pass_dist_q;
  assign out_idx_o  = pass_idx_q;
  assign out_lbl_o  = pass_lbl_q;
  assign occ_o      = occ_q;
  assign idx_o      = idx_q;
  assign lbl_o      = lbl_q;

endmodule

`default_nettype wire

// ----- src/knn_checker.sv -----
// Port-level assertions for the classifier and the bind that attaches them.
// Depends on knn_pkg and the top level knn_binary_classifier.
`default_nettype none

module knn_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic                      in_func_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic                      prediction_i,
  input wire logic [1:0]                neighbors_found_i,
  input wire logic [knn_pkg::IDX_W-1:0] nearest_index_i
);

  // A stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(prediction_i) &&
      $stable(neighbors_found_i) && $stable(nearest_index_i))
    else $error("result changed while stalled");

  // No neighbors means a zero vote and slot zero
  a_empty_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (neighbors_found_i == 2'd0) |->
      !prediction_i && (nearest_index_i == '0))
    else $error("empty vote with nonzero result");

  // A classify keeps the block busy in the next cycle
  a_busy_after_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == knn_pkg::FUNC_CLASSIFY) |=> !in_ready_i)
    else $error("input ready right after a classify");

  // A new result only appears out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised while idle");

endmodule

bind knn_binary_classifier knn_checker u_knn_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .in_func_i         (in_i.func),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .prediction_i      (out_o.prediction),
  .neighbors_found_i (out_o.neighbors_found),
  .nearest_index_i   (out_o.nearest_index)
);

`default_nettype wire
